### rtl/core/pid_differential_servo_steer_top_defines.svh
// ----------------------------------------------------------------------------
// PID differential servo steer - assertion macros
// Concurrent assertion wrappers shared by the steering controller RTL.
// ----------------------------------------------------------------------------
`ifndef PID_DIFFERENTIAL_SERVO_STEER_TOP_DEFINES_SVH
`define PID_DIFFERENTIAL_SERVO_STEER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define PDSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdss assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define PDSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdss assertion failed");
`else
`define PDSS_ASSERT_IMP(lbl, ante, cons)
`define PDSS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### rtl/core/pdss_pkg.sv
// ----------------------------------------------------------------------------
// pdss_pkg
// Types and constants of the PID differential servo steering controller.
// ----------------------------------------------------------------------------
package pdss_pkg;

  localparam int CFG_ADDR_W = 4;

  // register indexes (word address bits [3:2])
  localparam logic [1:0] REG_GAIN_PROP  = 2'd0;
  localparam logic [1:0] REG_GAIN_INTEG = 2'd1;
  localparam logic [1:0] REG_GAIN_DERIV = 2'd2;
  localparam logic [1:0] REG_PULSE_SPAN = 2'd3;

  localparam logic signed [31:0] GAIN_PROP_RST  = 32'sd196608;
  localparam logic signed [31:0] GAIN_INTEG_RST = -32'sd66;
  localparam logic signed [31:0] GAIN_DERIV_RST = 32'sd1048576;
  localparam logic [9:0]         PULSE_SPAN_RST = 10'd500;

  localparam logic signed [17:0] ERR_MID      = 18'sd32768;
  localparam logic signed [17:0] CTRL_MAX     = 18'sd65536;
  localparam logic signed [47:0] CTRL_MAX_48  = 48'sd65536;
  localparam logic [16:0]        Q16_ONE      = 17'd65536;
  localparam logic [11:0]        PULSE_CENTER = 12'd1500;
  localparam logic [20:0]        RIGHT_SCALE  = 21'd52429;
  localparam logic [43:0]        CEIL_BIAS    = 44'hFFFF_FFFF;

  localparam logic signed [39:0] INTEG_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] INTEG_MIN = {1'b1, {39{1'b0}}};
  localparam logic signed [71:0] PROD_SAT  = 72'sd1 <<< 62;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_MP    = 12'b0000_0000_0010,
    ST_MD    = 12'b0000_0000_0100,
    ST_MIL   = 12'b0000_0000_1000,
    ST_MIH   = 12'b0000_0001_0000,
    ST_ISAT  = 12'b0000_0010_0000,
    ST_ISUM  = 12'b0000_0100_0000,
    ST_CLAMP = 12'b0000_1000_0000,
    ST_ML    = 12'b0001_0000_0000,
    ST_MR1   = 12'b0010_0000_0000,
    ST_MR2   = 12'b0100_0000_0000,
    ST_DONE  = 12'b1000_0000_0000
  } pdss_state_t;

endpackage

### rtl/core/pid_differential_servo_steer_top.sv
// ----------------------------------------------------------------------------
// pid_differential_servo_steer_top
// PID line-following steering that drives two wheel servos by pulse width.
// ----------------------------------------------------------------------------
// Each input item is one line-position sample (0x0000..0xFFFF for 0..1). The
// block forms error = 0.5 - position in Q16, updates a saturating 40-bit
// integrator and the derivative against the previous error, weights the
// three terms with the signed Q16.16 gains, clamps the control to [-1, 1] and
// mixes it into left and right servo pulse widths in microseconds. All seven
// products (three PID terms with the integral term in two halves, and three
// pulse scalings) go in turn through a single shared 33x21-bit signed
// multiplier under a one-hot sequencer, and the next item is taken only once
// the previous result is loaded into the output register, so a new sample
// cannot start before the last one is through.
// The input is not ready while a sample is in work; gains and pulse span are
// written over the APB-style port, and the user must write them only while
// the block is idle; the block itself does not enforce this.
`include "pid_differential_servo_steer_top_defines.svh"

module pid_differential_servo_steer_top
  import pdss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] position
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // [11:0] left_pulse, [22:12] right_pulse,
                                            // [40:23] steer_effort, [47:41] zero
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [31:0] gain_prop_r, gain_integ_r, gain_deriv_r;
  logic [9:0]         pulse_span_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r  <= GAIN_PROP_RST;
      gain_integ_r <= GAIN_INTEG_RST;
      gain_deriv_r <= GAIN_DERIV_RST;
      pulse_span_r <= PULSE_SPAN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_GAIN_PROP:  gain_prop_r  <= cfg_pwdata;
        REG_GAIN_INTEG: gain_integ_r <= cfg_pwdata;
        REG_GAIN_DERIV: gain_deriv_r <= cfg_pwdata;
        REG_PULSE_SPAN: pulse_span_r <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_GAIN_PROP:  cfg_prdata = gain_prop_r;
      REG_GAIN_INTEG: cfg_prdata = gain_integ_r;
      REG_GAIN_DERIV: cfg_prdata = gain_deriv_r;
      REG_PULSE_SPAN: cfg_prdata = {22'd0, pulse_span_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  pdss_state_t        state_r, state_nxt;
  logic signed [39:0] integral_r;     // controller state: integrator
  logic signed [17:0] prev_err_r;     // controller state: last error
  logic signed [17:0] err_r, deriv_r;
  logic signed [53:0] prod_r;         // registered multiplier output
  logic signed [71:0] ip_r;           // integral product, then its saturated value
  logic signed [63:0] acc_r;          // weighted sum
  logic signed [17:0] ctrl_r;         // clamped control
  logic [11:0]        left_r;
  logic               out_valid_r;
  logic [11:0]        out_left_r;
  logic [10:0]        out_right_r;
  logic signed [17:0] out_effort_r;

  logic in_acc, load_out;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Error, integrator and derivative of the incoming sample
  logic signed [17:0] err_w;
  logic signed [40:0] integ_sum_w;
  logic signed [39:0] integ_w;
  logic signed [18:0] deriv_w;

  always_comb begin
    err_w       = ERR_MID - $signed({2'b00, in_tdata[15:0]});
    integ_sum_w = {integral_r[39], integral_r} + {{23{err_w[17]}}, err_w};
    priority if (integ_sum_w[40] == integ_sum_w[39]) begin
      integ_w = integ_sum_w[39:0];
    end else if (!integ_sum_w[40]) begin
      integ_w = INTEG_MAX;
    end else begin
      integ_w = INTEG_MIN;
    end
    deriv_w = {err_w[17], err_w} - {prev_err_r[17], prev_err_r};
  end

  // Steering mix: positive control slows the left wheel, negative the right
  logic [16:0] left_factor, right_factor;

  always_comb begin
    left_factor  = Q16_ONE;
    right_factor = Q16_ONE;
    if (ctrl_r > 18'sd0) begin
      left_factor = Q16_ONE - 17'(unsigned'(ctrl_r));
    end
    if (ctrl_r < 18'sd0) begin
      right_factor = 17'(unsigned'(18'(Q16_ONE) + unsigned'(ctrl_r)));
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier: select operands by step
  // --------------------------------------------------------------------------
  logic signed [32:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [53:0] mul_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MP: begin
        mul_a = {gain_prop_r[31], gain_prop_r};
        mul_b = {{3{err_r[17]}}, err_r};
      end
      ST_MD: begin
        mul_a = {gain_deriv_r[31], gain_deriv_r};
        mul_b = {{3{deriv_r[17]}}, deriv_r};
      end
      ST_MIL: begin
        mul_a = {gain_integ_r[31], gain_integ_r};
        mul_b = {1'b0, integral_r[19:0]};
      end
      ST_MIH: begin
        mul_a = {gain_integ_r[31], gain_integ_r};
        mul_b = {integral_r[39], integral_r[39:20]};
      end
      ST_ML: begin
        mul_a = {16'd0, left_factor};
        mul_b = {11'd0, pulse_span_r};
      end
      ST_MR1: begin
        mul_a = {16'd0, right_factor};
        mul_b = {11'd0, pulse_span_r};
      end
      ST_MR2: begin
        mul_a = {6'd0, prod_r[26:0]};
        mul_b = RIGHT_SCALE;
      end
      default: ;
    endcase
  end

  assign mul_q = mul_a * mul_b;

  // Integral product: join halves and saturate to +/-2^62
  logic signed [71:0] ip_sum_w, ip_sat_w;
  always_comb begin
    ip_sum_w = ip_r + $signed({prod_r[51:0], 20'd0});
    priority if (ip_sum_w > PROD_SAT) begin
      ip_sat_w = PROD_SAT;
    end else if (ip_sum_w < -PROD_SAT) begin
      ip_sat_w = -PROD_SAT;
    end else begin
      ip_sat_w = ip_sum_w;
    end
  end

  // Control: floor of the sum by 2^16, clamped to [-1, 1]
  logic signed [47:0] ctrl_full_w;
  logic signed [17:0] ctrl_w;
  always_comb begin
    ctrl_full_w = acc_r[63:16];
    priority if (ctrl_full_w > CTRL_MAX_48) begin
      ctrl_w = CTRL_MAX;
    end else if (ctrl_full_w < -CTRL_MAX_48) begin
      ctrl_w = -CTRL_MAX;
    end else begin
      ctrl_w = ctrl_full_w[17:0];
    end
  end

  // Right pulse: round the scaled decrement up, subtract from center
  logic [43:0] rdec_sum_w;
  logic [11:0] rdec_w;
  logic [10:0] right_w;
  always_comb begin
    rdec_sum_w = {1'b0, prod_r[42:0]} + CEIL_BIAS;
    rdec_w     = rdec_sum_w[43:32];
    right_w    = 11'(PULSE_CENTER - rdec_w);
  end

  // Next step
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_MP;
      ST_MP:    state_nxt = ST_MD;
      ST_MD:    state_nxt = ST_MIL;
      ST_MIL:   state_nxt = ST_MIH;
      ST_MIH:   state_nxt = ST_ISAT;
      ST_ISAT:  state_nxt = ST_ISUM;
      ST_ISUM:  state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_ML;
      ST_ML:    state_nxt = ST_MR1;
      ST_MR1:   state_nxt = ST_MR2;
      ST_MR2:   state_nxt = ST_DONE;
      ST_DONE:  if (load_out) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      integral_r  <= '0;
      prev_err_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        integral_r <= integ_w;
        prev_err_r <= err_w;
      end
      // hold the result until taken; load the next one in its place
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        err_r   <= err_w;
        deriv_r <= deriv_w[17:0];
        acc_r   <= '0;
      end
      ST_MP: begin
        prod_r <= mul_q;
      end
      ST_MD, ST_MIL: begin
        acc_r  <= acc_r + {{10{prod_r[53]}}, prod_r};
        prod_r <= mul_q;
      end
      ST_MIH: begin
        ip_r   <= {{18{prod_r[53]}}, prod_r};
        prod_r <= mul_q;
      end
      ST_ISAT: begin
        ip_r <= ip_sat_w;
      end
      ST_ISUM: begin
        acc_r <= acc_r + ip_r[63:0];
      end
      ST_CLAMP: begin
        ctrl_r <= ctrl_w;
      end
      ST_ML: begin
        prod_r <= mul_q;
      end
      ST_MR1: begin
        left_r <= PULSE_CENTER + {2'd0, prod_r[25:16]};
        prod_r <= mul_q;
      end
      ST_MR2: begin
        prod_r <= mul_q;
      end
      ST_DONE: begin
        if (load_out) begin
          out_left_r   <= left_r;
          out_right_r  <= right_w;
          out_effort_r <= ctrl_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_effort_r, out_right_r, out_left_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PDSS_ASSERT_NXT(a_accept_starts, in_acc, state_r == ST_MP)
  `PDSS_ASSERT_NXT(a_ctrl_clamped, state_r == ST_CLAMP, (ctrl_r <= CTRL_MAX) && (ctrl_r >= -CTRL_MAX))
  `PDSS_ASSERT_IMP(a_load_from_done, load_out, !in_tready)
  `PDSS_ASSERT_NXT(a_load_sets_valid, load_out, out_tvalid && (state_r == ST_IDLE))

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - PID differential servo steer testbench
// Drives line-position samples into the steering controller over the input
// stream, predicts left/right servo pulses and the clamped steering effort
// with its own fixed-point PID model, and checks every result item in order.
// Gains and pulse span are reprogrammed over the APB port between phases.
// ----------------------------------------------------------------------------
module tb;
  import pdss_pkg::*;

  // One result item as it leaves the block.
  typedef struct {
    logic [11:0]        left_pulse;
    logic [10:0]        right_pulse;
    logic signed [17:0] steer_effort;
  } servo_cmd_t;

  // One row of the directed table; the expected fields count only when typed.
  typedef struct packed {
    logic [15:0] position;
    logic        typed;
    logic [11:0] left_pulse;
    logic [10:0] right_pulse;
    logic [17:0] steer_effort;
  } probe_row_t;

  localparam int  CYCLE_LIMIT  = 6_000_000;
  localparam int  SETTLE_CYC   = 16;
  localparam int  HOLD_CYC     = 400;      // long receiver back-pressure
  localparam int  PHASE_ITEMS  = 70;
  localparam int  FILL_ITEMS   = 40;       // wind the integrator up
  localparam int  IDLE_PCT     = 21;
  localparam longint INTEG_TOP = (longint'(1) <<< 39) - 1;
  localparam longint INTEG_BOT = -(longint'(1) <<< 39);
  localparam logic signed [71:0] PRODUCT_CAP = 72'sd1 <<< 62;

  // Directed rows, all at reset configuration. The typed rows are centered
  // line from a cleared integrator, then hard left and hard right.
  localparam int N_PROBES = 17;
  localparam probe_row_t PROBES [N_PROBES] = '{
    '{16'h8000, 1'b1, 12'd2000, 11'd1099, 18'h00000},
    '{16'h0000, 1'b1, 12'd1500, 11'd1099, 18'h10000},
    '{16'hFFFF, 1'b1, 12'd2000, 11'd1500, 18'h30000},
    '{16'h8000, 1'b0, 12'd0, 11'd0, 18'd0},
    '{16'h8001, 1'b0, 12'd0, 11'd0, 18'd0},
    '{16'h7FFF, 1'b0, 12'd0, 11'd0, 18'd0},
    '{16'h8000, 1'b0, 12'd0, 11'd0, 18'd0},
    '{16'h8010, 1'b0, 12'd0, 11'd0, 18'd0},
    '{16'h7FF0, 1'b0, 12'd0, 11'd0, 18'd0},
    '{16'h8000, 1'b0, 12'd0, 11'd0, 18'd0},
    '{16'h4000, 1'b0, 12'd0, 11'd0, 18'd0},
    '{16'hC000, 1'b0, 12'd0, 11'd0, 18'd0},
    '{16'h0001, 1'b0, 12'd0, 11'd0, 18'd0},
    '{16'hFFFE, 1'b0, 12'd0, 11'd0, 18'd0},
    '{16'hAAAA, 1'b0, 12'd0, 11'd0, 18'd0},
    '{16'h5555, 1'b0, 12'd0, 11'd0, 18'd0},
    '{16'h8000, 1'b0, 12'd0, 11'd0, 18'd0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;    // [15:0] position
  logic                  out_tvalid;
  logic                  out_tready;
  logic [47:0]           out_tdata;   // [11:0] left_pulse, [22:12] right_pulse,
                                      // [40:23] steer_effort, [47:41] zero
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  // Shadow copy of the controller's registers and loop state.
  logic signed [31:0] kp, ki, kd;
  logic [9:0]         swing_us;
  longint             integ_acc;
  longint             last_err;

  servo_cmd_t pending_cmds[$];
  int         mismatch_count;
  int         cycle_count;
  bit         gaps_on;
  bit         stalls_on;
  int         hold_requests;
  int         hold_served;
  int         hold_left;

  pid_differential_servo_steer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Advance the shadow PID state by one sample and return the servo command.
  function automatic servo_cmd_t predict_servo_cmd(input logic [15:0] position);
    longint             err, acc, deriv, integ_term, total, ctrl, lf, rf;
    longint unsigned    ly, ry, rdec;
    logic signed [71:0] acc_w, gain_w, prod;
    servo_cmd_t         cmd;
    err = 64'sd32768 - longint'(position);
    acc = integ_acc + err;
    if (acc > INTEG_TOP) acc = INTEG_TOP;
    if (acc < INTEG_BOT) acc = INTEG_BOT;
    deriv     = err - last_err;
    integ_acc = acc;
    last_err  = err;
    // Saturate the integral product to +/-2^62 before summing.
    acc_w  = acc;
    gain_w = ki;
    prod   = acc_w * gain_w;
    if (prod > PRODUCT_CAP) prod = PRODUCT_CAP;
    if (prod < -PRODUCT_CAP) prod = -PRODUCT_CAP;
    integ_term = longint'(prod);
    total = err * longint'(kp) + deriv * longint'(kd) + integ_term;
    // Floor to Q16 and clamp to [-1, 1].
    ctrl = total >>> 16;
    if (ctrl > 64'sd65536) ctrl = 64'sd65536;
    if (ctrl < -64'sd65536) ctrl = -64'sd65536;
    // Positive control slows the left wheel, negative the right.
    lf   = (ctrl > 0) ? 64'sd65536 - ctrl : 64'sd65536;
    rf   = (ctrl < 0) ? 64'sd65536 + ctrl : 64'sd65536;
    ly   = (longint'(lf) * longint'(swing_us)) >> 16;
    ry   = longint'(rf) * longint'(swing_us) * 64'd52429;
    rdec = (ry + 64'hFFFF_FFFF) >> 32;
    cmd.left_pulse   = 12'(64'd1500 + ly);
    cmd.right_pulse  = 11'(64'd1500 - rdec);
    cmd.steer_effort = 18'(ctrl);
    return cmd;
  endfunction

  // Offer one sample; hold valid until the block takes it.
  task automatic send_position(input logic [15:0] position, input bit typed,
                               input servo_cmd_t typed_cmd);
    servo_cmd_t cmd;
    @(negedge clk);
    if (gaps_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid = 1'b0;
        in_tdata  = 16'($urandom);
        @(negedge clk);
      end
    end
    in_tvalid = 1'b1;
    in_tdata  = position;
    do @(posedge clk); while (!in_tready);
    cmd = predict_servo_cmd(position);
    pending_cmds.push_back(typed ? typed_cmd : cmd);
  endtask

  task automatic send_random(input logic [15:0] position);
    servo_cmd_t unused;
    unused = '{12'd0, 11'd0, 18'sd0};
    send_position(position, 1'b0, unused);
  endtask

  // Drop valid and wait until every expected item is back and the block is idle.
  task automatic drain;
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_GAIN_PROP:  kp = value;
      REG_GAIN_INTEG: ki = value;
      REG_GAIN_DERIV: kd = value;
      REG_PULSE_SPAN: swing_us = value[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic write_all(input logic [31:0] p, input logic [31:0] i,
                           input logic [31:0] d, input logic [9:0] span);
    write_reg(REG_GAIN_PROP, p);
    write_reg(REG_GAIN_INTEG, i);
    write_reg(REG_GAIN_DERIV, d);
    // Junk in the upper bits must be dropped by the 10-bit span register.
    write_reg(REG_PULSE_SPAN, {22'($urandom), span});
  endtask

  // Gain of at most +/-4.0, so the control lands mid-range often.
  function automatic logic [31:0] mild_gain;
    logic [31:0] g;
    g = $urandom_range(262144);
    return $urandom_range(1) ? -g : g;
  endfunction

  // Mix of full-range samples and samples near the line center.
  function automatic logic [15:0] pick_position;
    int unsigned sel;
    sel = $urandom_range(3);
    case (sel)
      0: return 16'($urandom);
      1: return 16'(32768 + int'($urandom_range(512)) - 256);
      2: return ($urandom_range(1) ? 16'hFFFF : 16'h0000);
      default: return 16'(32768 + int'($urandom_range(16384)) - 8192);
    endcase
  endfunction

  // Receiver: random stalls, a long hold on request, ready otherwise.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYC;
      out_tready  <= 1'b0;
    end else if (stalls_on) begin
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each accepted result item with the oldest expectation.
  always @(posedge clk) begin
    servo_cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_cmds.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected item, expected none actual %h", $time, out_tdata);
      end else begin
        want = pending_cmds.pop_front();
        if (out_tdata[11:0] !== want.left_pulse) begin
          mismatch_count++;
          $display("%0t: left_pulse expected %0d actual %0d", $time,
                   want.left_pulse, out_tdata[11:0]);
        end
        if (out_tdata[22:12] !== want.right_pulse) begin
          mismatch_count++;
          $display("%0t: right_pulse expected %0d actual %0d", $time,
                   want.right_pulse, out_tdata[22:12]);
        end
        if (out_tdata[40:23] !== want.steer_effort) begin
          mismatch_count++;
          $display("%0t: steer_effort expected %0d actual %0d", $time,
                   want.steer_effort, $signed(out_tdata[40:23]));
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    servo_cmd_t typed_cmd;
    // Hold every input at a known value from time zero.
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = 16'h0000;
    out_tready     = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = 32'h0;
    mismatch_count = 0;
    cycle_count    = 0;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    hold_requests  = 0;
    hold_served    = 0;
    hold_left      = 0;
    kp             = GAIN_PROP_RST;
    ki             = GAIN_INTEG_RST;
    kd             = GAIN_DERIV_RST;
    swing_us       = PULSE_SPAN_RST;
    integ_acc      = 0;
    last_err       = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table at reset configuration.
    for (int r = 0; r < N_PROBES; r++) begin
      typed_cmd.left_pulse   = PROBES[r].left_pulse;
      typed_cmd.right_pulse  = PROBES[r].right_pulse;
      typed_cmd.steer_effort = PROBES[r].steer_effort;
      send_position(PROBES[r].position, PROBES[r].typed, typed_cmd);
    end
    drain();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ;  // keep reset gains
        1: write_all(mild_gain(), mild_gain(), mild_gain(), 10'($urandom_range(1023)));
        2: write_all($urandom, $urandom, $urandom, 10'd1023);
        3: write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 10'd0);
        4: write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 10'd1000);
        default: write_all(mild_gain(), mild_gain(), mild_gain(),
                           10'($urandom_range(1023)));
      endcase
      // Run one phase clean: no gaps on either side.
      gaps_on   = (ph != 5);
      stalls_on = (ph != 5);
      // Stall the receiver long enough to back the block up into its input.
      if (ph == 2) hold_requests++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Pause the sender once until the pipeline is empty.
        if (ph == 1 && n == 40) begin
          @(negedge clk);
          in_tvalid = 1'b0;
          while (pending_cmds.size() != 0) @(posedge clk);
        end
        send_random(pick_position());
      end
      drain();
    end

    // Integrator wind-up: grow the integral with the strongest negative
    // gain, then flip the gain sign.
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_all(32'h0, 32'h8000_0000, 32'h0, 10'd700);
    for (int n = 0; n < FILL_ITEMS; n++) send_random(16'h0000);
    drain();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    write_reg(REG_GAIN_INTEG, 32'h7FFF_FFFF);
    for (int n = 0; n < 8; n++) send_random(pick_position());
    drain();
    // Small integral gain brings the wound-up term back into range.
    write_all(mild_gain(), 32'h0000_0001, mild_gain(), 10'($urandom_range(1023)));
    for (int n = 0; n < 16; n++) send_random(pick_position());
    drain();

    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/pdss_pkg.sv
rtl/core/pid_differential_servo_steer_top.sv
tb/tb.sv
